// ===== hw/rtl/zlhns_pkg.sv =====
// Shared constants and helpers for the ZIP local header name scanner.
// No dependencies; imported by every module of the block.
package zlhns_pkg;

  localparam int unsigned ByteW      = 8;
  localparam int unsigned NameLenW   = 16;
  localparam int unsigned HdrCountW  = 5;
  localparam int unsigned SigPosW    = 2;

  localparam logic [SigPosW-1:0]   SigLastPos  = 2'd3;
  localparam logic [HdrCountW-1:0] HdrLastOfs  = 5'd25;
  localparam logic [HdrCountW-1:0] LenLowOfs   = 5'd22;
  localparam logic [HdrCountW-1:0] LenHighOfs  = 5'd23;

  // Local file header signature, "PK\x03\x04".
  function automatic logic [ByteW-1:0] sig_byte(input logic [SigPosW-1:0] pos);
    logic [ByteW-1:0] val;
    case (pos)
      2'd0:    val = 8'h50;
      2'd1:    val = 8'h4B;
      2'd2:    val = 8'h03;
      default: val = 8'h04;
    endcase
    return val;
  endfunction

endpackage

// ===== hw/rtl/zip_local_header_name_scanner.sv =====
// ZIP local header name scanner: takes one file byte per request and returns the
// file names that follow each local file header signature. A byte is registered
// on entry, then one pass of compare-and-count logic updates the scanner state and
// loads the result register, so one byte is taken every cycle while the output
// side keeps up. Signature and header bytes give no result; each name byte gives
// one result, its last byte flagged by name_last_o. A header with a zero name
// length yields a single result with stopped_o set, after which bytes are still
// accepted but ignored until reset.
// Depends on zlhns_pkg, zlhns_in_stage and zlhns_core.
module zip_local_header_name_scanner import zlhns_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_ready_o,
  input  logic [ByteW-1:0] in_byte_i,
  output logic             out_valid_o,
  input  logic             out_ready_i,
  output logic [ByteW-1:0] name_byte_o,
  output logic             name_last_o,
  output logic             stopped_o
);

  logic             stg_valid;
  logic             stg_ready;
  logic [ByteW-1:0] stg_byte;

  zlhns_in_stage u_in_stage (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .up_valid_i (in_valid_i),
    .up_ready_o (in_ready_o),
    .up_byte_i  (in_byte_i),
    .dn_valid_o (stg_valid),
    .dn_ready_i (stg_ready),
    .dn_byte_o  (stg_byte)
  );

  zlhns_core u_core (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (stg_valid),
    .in_ready_o  (stg_ready),
    .in_byte_i   (stg_byte),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .name_byte_o (name_byte_o),
    .name_last_o (name_last_o),
    .stopped_o   (stopped_o)
  );

endmodule

// ===== hw/rtl/zlhns_in_stage.sv =====
// Input register stage of the ZIP local header name scanner.
// Depends on zlhns_pkg for the byte width.
module zlhns_in_stage import zlhns_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             up_valid_i,
  output logic             up_ready_o,
  input  logic [ByteW-1:0] up_byte_i,
  output logic             dn_valid_o,
  input  logic             dn_ready_i,
  output logic [ByteW-1:0] dn_byte_o
);

  logic             valid_q, valid_d;
  logic [ByteW-1:0] byte_q, byte_d;

  assign up_ready_o = !valid_q || dn_ready_i;
  assign dn_valid_o = valid_q;
  assign dn_byte_o  = byte_q;

  always_comb begin
    valid_d = valid_q;
    byte_d  = byte_q;
    if (up_ready_o) begin
      valid_d = up_valid_i;
      byte_d  = up_byte_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    byte_q <= byte_d;
  end

endmodule

// ===== hw/rtl/zlhns_core.sv =====
// Scanner state machine and result register.
// Depends on zlhns_pkg for the signature table and header offsets.
module zlhns_core import zlhns_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_ready_o,
  input  logic [ByteW-1:0] in_byte_i,
  output logic             out_valid_o,
  input  logic             out_ready_i,
  output logic [ByteW-1:0] name_byte_o,
  output logic             name_last_o,
  output logic             stopped_o
);

  typedef enum logic [1:0] {
    PhScan,
    PhHeader,
    PhName,
    PhStop
  } phase_e;

  phase_e               phase_q, phase_d;
  logic [SigPosW-1:0]   match_q, match_d;
  logic [HdrCountW-1:0] hdr_cnt_q, hdr_cnt_d;
  logic [ByteW-1:0]     len_low_q, len_low_d;
  logic [NameLenW-1:0]  remain_q, remain_d;

  logic             out_valid_q, out_valid_d;
  logic [ByteW-1:0] name_byte_q, name_byte_d;
  logic             name_last_q, name_last_d;
  logic             stopped_q, stopped_d;

  logic             take;
  logic             emit;
  logic [ByteW-1:0] res_byte;
  logic             res_last;
  logic             res_stop;

  // The result register may be refilled in the cycle it is drained.
  assign in_ready_o = !out_valid_q || out_ready_i;
  assign take       = in_valid_i && in_ready_o;

  always_comb begin
    phase_d   = phase_q;
    match_d   = match_q;
    hdr_cnt_d = hdr_cnt_q;
    len_low_d = len_low_q;
    remain_d  = remain_q;
    emit      = 1'b0;
    res_byte  = '0;
    res_last  = 1'b0;
    res_stop  = 1'b0;
    if (take) begin
      case (phase_q)
        PhScan: begin
          if (in_byte_i == sig_byte(match_q)) begin
            if (match_q == SigLastPos) begin
              match_d   = '0;
              hdr_cnt_d = '0;
              phase_d   = PhHeader;
            end else begin
              match_d = match_q + 1'b1;
            end
          end else begin
            // A byte that breaks a partial match may still start a new one.
            match_d = (in_byte_i == sig_byte('0)) ? SigPosW'(1) : '0;
          end
        end
        PhHeader: begin
          if (hdr_cnt_q == LenLowOfs) begin
            len_low_d = in_byte_i;
          end else if (hdr_cnt_q == LenHighOfs) begin
            remain_d = {in_byte_i, len_low_q};
          end
          if (hdr_cnt_q >= HdrLastOfs) begin
            hdr_cnt_d = '0;
            if (remain_q == '0) begin
              phase_d  = PhStop;
              emit     = 1'b1;
              res_stop = 1'b1;
            end else begin
              phase_d = PhName;
            end
          end else begin
            hdr_cnt_d = hdr_cnt_q + 1'b1;
          end
        end
        PhName: begin
          emit     = 1'b1;
          res_byte = in_byte_i;
          res_last = (remain_q <= NameLenW'(1));
          if (res_last) begin
            remain_d = '0;
            match_d  = '0;
            phase_d  = PhScan;
          end else begin
            remain_d = remain_q - 1'b1;
          end
        end
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    out_valid_d = out_valid_q;
    name_byte_d = name_byte_q;
    name_last_d = name_last_q;
    stopped_d   = stopped_q;
    if (in_ready_o) begin
      out_valid_d = take && emit;
      name_byte_d = res_byte;
      name_last_d = res_last;
      stopped_d   = res_stop;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q     <= PhScan;
      match_q     <= '0;
      hdr_cnt_q   <= '0;
      len_low_q   <= '0;
      remain_q    <= '0;
      out_valid_q <= 1'b0;
    end else begin
      phase_q     <= phase_d;
      match_q     <= match_d;
      hdr_cnt_q   <= hdr_cnt_d;
      len_low_q   <= len_low_d;
      remain_q    <= remain_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    name_byte_q <= name_byte_d;
    name_last_q <= name_last_d;
    stopped_q   <= stopped_d;
  end

  assign out_valid_o = out_valid_q;
  assign name_byte_o = name_byte_q;
  assign name_last_o = name_last_q;
  assign stopped_o   = stopped_q;

  a_stop_sticky: assert property (@(posedge clk_i) disable iff (!rst_ni)
    phase_q == PhStop |=> phase_q == PhStop)
    else $error("scanner left the stopped phase");

  a_name_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    phase_q == PhName |-> remain_q != '0)
    else $error("name phase entered with no name bytes left");

  a_stop_result_clean: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && stopped_q |-> !name_last_q && name_byte_q == '0)
    else $error("stop result carries name data");

  a_no_result_after_stop: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $past(phase_q == PhStop) && phase_q == PhStop && $rose(out_valid_q) |-> 1'b0)
    else $error("result produced while stopped");

endmodule

// ===== sim/tb_zip_local_header_name_scanner.sv =====
// Testbench for zip_local_header_name_scanner: random byte streams with embedded local headers,
// checked against a behavioral scanner model kept inside this file.
// Depends on zlhns_pkg and the RTL of the block.
`timescale 1ns / 1ps

module tb_zip_local_header_name_scanner;
  import zlhns_pkg::*;

  localparam logic [31:0] LocalHdrSig   = 32'h504B0304;
  localparam int unsigned RandomBytes   = 2000;
  localparam int unsigned HoldCycles    = 300;
  localparam int unsigned StallLimit    = 3000;
  localparam int unsigned DrainCycles   = 10;
  localparam int unsigned MaxErrorLines = 20;

  typedef enum logic [1:0] {PhScan, PhHeader, PhName, PhHalted} scan_phase_e;

  typedef struct packed {
    logic [ByteW-1:0] name_byte;
    logic             name_last;
    logic             stopped;
  } name_result_t;

  logic             clk_i = 1'b0;
  logic             rst_n = 1'b0;
  logic             in_valid = 1'b0;
  logic             in_ready_o;
  logic [ByteW-1:0] in_byte = '0;
  logic             out_valid_o;
  logic             out_ready = 1'b0;
  logic [ByteW-1:0] name_byte_o;
  logic             name_last_o;
  logic             stopped_o;

  logic [ByteW-1:0] pending_bytes [$];
  name_result_t     expected_names [$];

  // Scanner state mirrored by the predictor.
  scan_phase_e          scan_phase = PhScan;
  logic [SigPosW-1:0]   sig_pos = '0;
  logic [HdrCountW-1:0] hdr_count = '0;
  logic [ByteW-1:0]     len_low = '0;
  logic [NameLenW-1:0]  name_left = '0;

  int unsigned n_total = 0;
  int unsigned n_in_acc = 0;
  int unsigned n_err = 0;
  int unsigned idle_cycles = 0;
  int unsigned hold_left = 0;
  int unsigned hold_at = 0;
  logic        hold_done = 1'b0;
  logic        in_fire = 1'b0;

  zip_local_header_name_scanner i_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_n),
    .in_valid_i (in_valid),
    .in_ready_o (in_ready_o),
    .in_byte_i  (in_byte),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready),
    .name_byte_o(name_byte_o),
    .name_last_o(name_last_o),
    .stopped_o  (stopped_o)
  );

  always #5 clk_i = ~clk_i;

  function automatic logic [ByteW-1:0] sig_at(input logic [SigPosW-1:0] pos);
    return LocalHdrSig[31 - 8 * int'(pos) -: 8];
  endfunction

  // The receiver idles more than the sender at first, then the sender more, then neither idles.
  function automatic int unsigned idle_pct(input bit is_sender);
    if (n_in_acc < n_total / 3) begin
      return is_sender ? 38 : 59;
    end else if (n_in_acc < 2 * (n_total / 3)) begin
      return is_sender ? 59 : 38;
    end
    return 0;
  endfunction

  task automatic report_error(input string msg);
    if (n_err < MaxErrorLines) begin
      $display("ERROR at %0t: %s", $time, msg);
    end
    n_err++;
  endtask

  task automatic predict_names(input logic [ByteW-1:0] b);
    name_result_t res;
    case (scan_phase)
      PhScan: begin
        if (b == sig_at(sig_pos)) begin
          if (sig_pos == SigLastPos) begin
            sig_pos    = '0;
            hdr_count  = '0;
            scan_phase = PhHeader;
          end else begin
            sig_pos = sig_pos + 1'b1;
          end
        end else begin
          // A byte that breaks a partial match may itself start a new signature.
          sig_pos = (b == sig_at(2'd0)) ? 2'd1 : 2'd0;
        end
      end
      PhHeader: begin
        if (hdr_count == LenLowOfs) begin
          len_low = b;
        end else if (hdr_count == LenHighOfs) begin
          name_left = {b, len_low};
        end
        if (hdr_count >= HdrLastOfs) begin
          hdr_count = '0;
          if (name_left == '0) begin
            scan_phase = PhHalted;
            res = '{name_byte: '0, name_last: 1'b0, stopped: 1'b1};
            expected_names.push_back(res);
          end else begin
            scan_phase = PhName;
          end
        end else begin
          hdr_count = hdr_count + 1'b1;
        end
      end
      PhName: begin
        res = '{name_byte: b, name_last: (name_left <= 1), stopped: 1'b0};
        expected_names.push_back(res);
        if (name_left <= 1) begin
          name_left  = '0;
          sig_pos    = '0;
          scan_phase = PhScan;
        end else begin
          name_left = name_left - 1'b1;
        end
      end
      default: begin
      end
    endcase
  endtask

  task automatic queue_noise(input int unsigned n);
    for (int unsigned i = 0; i < n; i++) begin
      pending_bytes.push_back(ByteW'($urandom_range(0, 255)));
    end
  endtask

  task automatic queue_signature();
    for (int i = 0; i < 4; i++) begin
      pending_bytes.push_back(sig_at(i[SigPosW-1:0]));
    end
  endtask

  task automatic queue_header(input logic [NameLenW-1:0] len);
    queue_noise(22);
    pending_bytes.push_back(len[7:0]);
    pending_bytes.push_back(len[15:8]);
    queue_noise(2);
  endtask

  task automatic queue_entry(input logic [NameLenW-1:0] len);
    queue_signature();
    queue_header(len);
    queue_noise(int'(len));
  endtask

  // Driver: offers the next pending byte unless it decides to idle.
  always @(negedge clk_i) begin : drive_requests
    if (rst_n) begin
      if (in_valid && !in_fire) begin
        // Request still waiting for acceptance; hold it.
      end else if (pending_bytes.size() != 0 && $urandom_range(0, 99) >= idle_pct(1'b1)) begin
        in_valid <= 1'b1;
        in_byte  <= pending_bytes.pop_front();
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // Receiver: random stalls, plus one long hold-off so the block backs up.
  always @(negedge clk_i) begin : drive_ready
    if (hold_left > 0) begin
      out_ready <= 1'b0;
      hold_left <= hold_left - 1;
    end else if (!hold_done && hold_at != 0 && n_in_acc >= hold_at) begin
      hold_done <= 1'b1;
      hold_left <= HoldCycles;
      out_ready <= 1'b0;
    end else begin
      out_ready <= ($urandom_range(0, 99) >= idle_pct(1'b0));
    end
  end

  always @(posedge clk_i) begin : monitor
    name_result_t want;
    if (rst_n) begin
      if (out_valid_o && out_ready) begin
        if (expected_names.size() == 0) begin
          report_error($sformatf("unexpected result: byte %02h last %0b stopped %0b",
                                 name_byte_o, name_last_o, stopped_o));
        end else begin
          want = expected_names.pop_front();
          if (name_byte_o !== want.name_byte) begin
            report_error($sformatf("name_byte %02h, expected %02h", name_byte_o, want.name_byte));
          end
          if (name_last_o !== want.name_last) begin
            report_error($sformatf("name_last %0b, expected %0b", name_last_o, want.name_last));
          end
          if (stopped_o !== want.stopped) begin
            report_error($sformatf("stopped %0b, expected %0b", stopped_o, want.stopped));
          end
        end
      end
      if (in_valid && in_ready_o) begin
        predict_names(in_byte);
        n_in_acc++;
      end
      in_fire <= in_valid && in_ready_o;

      if ((in_valid && in_ready_o) || (out_valid_o && out_ready)) begin
        idle_cycles = 0;
      end else begin
        idle_cycles++;
      end
      if (idle_cycles >= StallLimit) begin
        $display("watchdog: no request moved for %0d cycles", StallLimit);
        $display("== FAIL ==");
        $finish;
      end
    end
  end

  initial begin : stimulus
    int unsigned pick;
    logic [ByteW-1:0] bad;

    // Directed: byte extremes, a match broken by a repeated first byte, a match
    // broken at the last position, then a name that itself looks like a signature.
    pending_bytes.push_back(8'h00);
    pending_bytes.push_back(8'hFF);
    pending_bytes.push_back(8'h50);
    pending_bytes.push_back(8'h50);
    pending_bytes.push_back(8'h4B);
    pending_bytes.push_back(8'h03);
    pending_bytes.push_back(8'h50);
    queue_signature();
    queue_header(16'd4);
    queue_signature();
    pending_bytes.push_back(8'h00);
    pending_bytes.push_back(8'hFF);
    queue_entry(16'd1);

    // Random: mostly well-formed entries, the rest noise and broken signatures.
    while (pending_bytes.size() < RandomBytes) begin
      pick = $urandom_range(0, 99);
      if (pick < 70) begin
        queue_noise($urandom_range(0, 4));
        pick = $urandom_range(0, 99);
        if (pick < 85) begin
          queue_entry(NameLenW'($urandom_range(1, 12)));
        end else if (pick < 97) begin
          queue_entry(NameLenW'($urandom_range(13, 64)));
        end else begin
          queue_entry(NameLenW'($urandom_range(256, 300)));
        end
        queue_noise($urandom_range(0, 6));
      end else if (pick < 85) begin
        pick = $urandom_range(1, 3);
        for (int unsigned i = 0; i < pick; i++) begin
          pending_bytes.push_back(sig_at(i[SigPosW-1:0]));
        end
        do begin
          bad = ByteW'($urandom_range(0, 255));
        end while (bad == sig_at(pick[SigPosW-1:0]));
        pending_bytes.push_back(bad);
      end else begin
        queue_noise($urandom_range(1, 8));
      end
    end

    // A zero name length halts the block for good, so it comes last; what
    // follows it must be taken and ignored.
    queue_noise(3);
    queue_entry(16'd0);
    queue_entry(16'd3);
    queue_noise(8);

    n_total = pending_bytes.size();
    hold_at = (n_total * 4) / 5;

    repeat (11) @(posedge clk_i);
    @(negedge clk_i);
    rst_n <= 1'b1;

    while (pending_bytes.size() != 0 || in_valid) @(posedge clk_i);
    while (expected_names.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);

    if (expected_names.size() != 0) begin
      report_error($sformatf("%0d results never arrived", expected_names.size()));
    end
    if (n_err == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
hw/rtl/zlhns_pkg.sv
hw/rtl/zlhns_in_stage.sv
hw/rtl/zlhns_core.sv
hw/rtl/zip_local_header_name_scanner.sv
sim/tb_zip_local_header_name_scanner.sv
